FILE: rtl/dbc_pkg.sv
// shared types, codes and defaults of the block buffer cache
package dbc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int TAG_W       = 36;

  // request function codes
  localparam logic [1:0] FN_GET   = 2'd0;
  localparam logic [1:0] FN_WRITE = 2'd1;
  localparam logic [1:0] FN_DONE  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_APPLY
  } ctl_state_t;

  typedef struct packed {
    logic cap;    // capture a new request, restart the scan
    logic rd;     // read the tag store at the scan address
    logic apply;  // update the marks and register the result
  } dbc_cmd_t;

  typedef struct packed {
    logic in_get;     // request at the ports is a get
    logic last_addr;  // scan address is the last entry
  } dbc_sts_t;

endpackage

FILE: rtl/dbc_ctrl.sv
// controller state machine of the block buffer cache
module dbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dbc_pkg::dbc_sts_t sts,
  output dbc_pkg::dbc_cmd_t cmd,
  output logic              busy
);
  import dbc_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.cap    = 1'b1;
          state_next = sts.in_get ? S_SCAN : S_APPLY;
        end
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.last_addr) begin
          state_next = S_DRAIN;
        end
      end
      // last tag read is being compared
      S_DRAIN: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/dbc_datapath.sv
// tag store, entry marks, scan and result registers of the block buffer cache
module dbc_datapath #(
  parameter int ENTRIES = dbc_pkg::ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  dbc_pkg::dbc_cmd_t cmd,
  output dbc_pkg::dbc_sts_t sts,
  input  logic [1:0]        func,
  input  logic [7:0]        device,
  input  logic [27:0]       block_number,
  input  logic [3:0]        entry_index,
  output logic              done,
  output logic [3:0]        entry,
  output logic              hit,
  output logic              was_busy,
  output logic              needs_read,
  output logic [1:0]        status
);
  import dbc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  // tag store, no reset: an entry is only matched once its used mark is set
  logic [TAG_W-1:0] tag_mem [ENTRIES];

  logic [ENTRIES-1:0] used;
  logic [ENTRIES-1:0] busy_m;
  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] dirty;

  logic [1:0]       req_func;
  logic [TAG_W-1:0] req_tag;
  logic [3:0]       req_idx;

  logic [IDX_W-1:0] cnt;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [TAG_W-1:0] rd_tag;

  logic             found_hit;
  logic [IDX_W-1:0] hit_idx;
  logic             found_free;
  logic [IDX_W-1:0] free_idx;

  logic             rd_match;
  logic             rd_free;
  logic             idx_ok;
  logic [IDX_W-1:0] widx;
  logic             do_alloc;

  assign sts.in_get    = (func == FN_GET);
  assign sts.last_addr = (cnt == IDX_W'(ENTRIES - 1));

  assign rd_match = rd_vld && used[rd_idx] && (rd_tag == req_tag);
  assign rd_free  = rd_vld && !dirty[rd_idx] && !busy_m[rd_idx];
  assign idx_ok   = (32'(req_idx) < ENTRIES);
  assign widx     = IDX_W'(req_idx);
  assign do_alloc = cmd.apply && (req_func == FN_GET) && !found_hit && found_free;

  // tag store ports
  always_ff @(posedge clk) begin
    if (do_alloc) begin
      tag_mem[free_idx] <= req_tag;
    end
    if (cmd.rd) begin
      rd_tag <= tag_mem[cnt];
    end
  end

  // request capture and scan pointers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_func <= func;
      req_tag  <= {device, block_number};
      req_idx  <= entry_index;
    end
    if (cmd.rd) begin
      rd_idx <= cnt;
    end
    if (rd_match && !found_hit) begin
      hit_idx <= rd_idx;
    end
    if (rd_free && !found_free) begin
      free_idx <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      rd_vld     <= 1'b0;
      found_hit  <= 1'b0;
      found_free <= 1'b0;
    end else begin
      rd_vld <= cmd.rd;
      if (cmd.cap) begin
        cnt        <= '0;
        found_hit  <= 1'b0;
        found_free <= 1'b0;
      end else begin
        if (cmd.rd) begin
          cnt <= cnt + 1'b1;
        end
        if (rd_match) begin
          found_hit <= 1'b1;
        end
        if (rd_free) begin
          found_free <= 1'b1;
        end
      end
    end
  end

  // entry marks and result
  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= '0;
      busy_m <= '0;
      valid  <= '0;
      dirty  <= '0;
      done   <= 1'b0;
    end else begin
      done <= cmd.apply;
      if (cmd.apply) begin
        case (req_func)
          FN_GET: begin
            if (found_hit) begin
              busy_m[hit_idx] <= 1'b1;
            end else if (found_free) begin
              used[free_idx]   <= 1'b1;
              busy_m[free_idx] <= 1'b1;
              valid[free_idx]  <= 1'b0;
              dirty[free_idx]  <= 1'b0;
            end
          end
          FN_WRITE: begin
            if (idx_ok && used[widx] && !busy_m[widx]) begin
              dirty[widx] <= 1'b1;
            end
          end
          FN_DONE: begin
            if (idx_ok) begin
              valid[widx] <= 1'b1;
              dirty[widx] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      entry      <= '0;
      hit        <= 1'b0;
      was_busy   <= 1'b0;
      needs_read <= 1'b0;
      status     <= ST_OK;
      case (req_func)
        FN_GET: begin
          if (found_hit) begin
            entry      <= 4'(hit_idx);
            hit        <= 1'b1;
            was_busy   <= busy_m[hit_idx];
            needs_read <= !valid[hit_idx];
          end else if (found_free) begin
            entry      <= 4'(free_idx);
            needs_read <= 1'b1;
          end else begin
            status <= ST_FULL;
          end
        end
        FN_WRITE: begin
          entry <= req_idx;
          if (!(idx_ok && used[widx] && !busy_m[widx])) begin
            status <= ST_REJECT;
          end
        end
        FN_DONE: begin
          entry <= req_idx;
          if (!idx_ok) begin
            status <= ST_REJECT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // a hit entry is left busy
  a_hit_busy: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> busy_m[hit_idx])
    else $error("hit entry not marked busy");

  // a full result means no entry was free
  a_full_none_free: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> (busy_m | dirty) == {ENTRIES{1'b1}})
    else $error("full reported with a free entry");

  // needs_read on a hit mirrors the valid mark
  a_hit_read: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> needs_read == !valid[hit_idx])
    else $error("needs_read disagrees with valid mark");

endmodule

FILE: rtl/disk_block_buffer_cache.sv
// top level of the disk block buffer cache lookup
// A table of ENTRIES buffer entries, each tagged by device and block number
// and carrying used, busy, valid and dirty marks. A transaction is taken on a
// clock edge with start high and busy low. A get (func 0) walks the tag store
// once, one entry per cycle, noting the lowest used entry whose tag matches
// and the lowest entry that is neither busy nor dirty, through the single
// read port of the tag store; its result is registered after the scan, the
// compare of the last read and the update. A write mark (func 1) or a
// completion (func 2) needs no scan and its result is registered after the
// update. The result is on entry, hit, was_busy, needs_read and status for
// exactly one cycle, marked by done, and must be taken then since it cannot
// be held off. busy is already low during that cycle, so the next
// transaction may start there. Only one transaction is in flight at a time.
module disk_block_buffer_cache #(
  parameter int ENTRIES = dbc_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [7:0]  device,
  input  logic [27:0] block_number,
  input  logic [3:0]  entry_index,
  output logic        done,
  output logic [3:0]  entry,
  output logic        hit,
  output logic        was_busy,
  output logic        needs_read,
  output logic [1:0]  status
);
  import dbc_pkg::*;

  // command and status between controller and datapath
  dbc_cmd_t cmd;
  dbc_sts_t sts;

  // sequencing: idle, tag scan, compare of the last read, update
  dbc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // tag store, entry marks and the registered result
  dbc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (func),
    .device       (device),
    .block_number (block_number),
    .entry_index  (entry_index),
    .done         (done),
    .entry        (entry),
    .hit          (hit),
    .was_busy     (was_busy),
    .needs_read   (needs_read),
    .status       (status)
  );

endmodule
